// File: rtl/ftig_pkg.sv
// shared widths and types for the flat terrain index generator
// no dependencies; imported by ftig_quad_calc and flat_terrain_index_generator
package ftig_pkg;

    localparam int SIDE_W  = 9;
    localparam int IDX_W   = 17;
    localparam int ROWLEN_W = SIDE_W + 1;
    localparam int BEATS   = 6;
    localparam int BEAT_W  = 3;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [IDX_W-1:0]  vidx_t;
    typedef logic [BEAT_W-1:0] beat_t;

    typedef struct packed {
        logic last_row;
        logic second_row;
        logic rh;
        logic mesh_end;
    } quad_flags_t;

endpackage

// File: rtl/ftig_quad_calc.sv
// corner and emission-order logic for one quad of the terrain grid
// depends on ftig_pkg
module ftig_quad_calc #(
    parameter int ROW_W = 8
) (
    input  logic [ROW_W-1:0]     row,
    input  logic [ROW_W-1:0]     col,
    input  ftig_pkg::side_t      side_n,
    input  ftig_pkg::quad_flags_t flags,
    output ftig_pkg::vidx_t      vert [ftig_pkg::BEATS]
);
    import ftig_pkg::*;

    localparam int PROD_W = ROW_W + ROWLEN_W;

    logic [ROWLEN_W-1:0] rowlen;
    logic [PROD_W-1:0]   prod;
    vidx_t base, col_x, col_x2, tl, tr, bl, br;

    always_comb begin
        rowlen = ROWLEN_W'({side_n - SIDE_W'(1), 1'b0});
        prod   = PROD_W'(row) * PROD_W'(rowlen);
        base   = IDX_W'(prod);
        col_x  = IDX_W'(col);
        col_x2 = IDX_W'({col, 1'b0});
        if (flags.last_row) begin
            tl = base + col_x;
            bl = tl + IDX_W'(side_n);
        end else if (flags.second_row) begin
            tl = base + col_x2;
            bl = tl + IDX_W'(rowlen) - col_x;
        end else begin
            tl = base + col_x2;
            bl = tl + IDX_W'(rowlen);
        end
        tr = tl + IDX_W'(1);
        br = bl + IDX_W'(1);

        vert[0] = tl;
        vert[1] = bl;
        vert[2] = flags.rh ? br : tr;
        if (flags.last_row) begin
            vert[3] = br;
            vert[4] = tr;
            vert[5] = flags.rh ? tl : bl;
        end else begin
            vert[3] = tr;
            vert[4] = flags.rh ? tl : bl;
            vert[5] = br;
        end
    end

endmodule

// File: rtl/flat_terrain_index_generator.sv
// top level of the flat terrain index generator: quad counters, request and index registers
// depends on ftig_pkg and ftig_quad_calc
//
// Each request beat yields six vertex indices (two triangles of one quad), one per output
// beat; the single output port, one index per beat while m_axis_tready is high, limits the
// request rate. A request is taken when the request register is free or empties in that
// cycle: the quad counters advance at once and the quad waits in the request register while
// the previous quad streams out. Its six indices are loaded into the index register as the
// previous quad's sixth beat leaves; with the output idle, the request register takes the
// quad and the index register then loads its indices and raises the first index valid.
// tlast marks the sixth index of each quad, tuser the sixth index of the final quad of the
// mesh. The side length register may be written only while no request is outstanding.
module flat_terrain_index_generator #(
    parameter int MAX_SIDE = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ftig_pkg::SIDE_W-1:0] cfg_data,       // side_vertices
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ftig_pkg::S_DATA_W-1:0] s_axis_tdata, // [0] restart, rest zero
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ftig_pkg::M_DATA_W-1:0] m_axis_tdata, // [16:0] vertex_index, rest zero
    output logic                        m_axis_tlast,   // last_of_quad
    output logic                        m_axis_tuser    // last_of_mesh
);
    import ftig_pkg::*;

    localparam int ROW_W = $clog2(MAX_SIDE);

    side_t side_reg;
    side_t n_eff, last_q;

    logic [ROW_W-1:0] row_reg, col_reg, row_next, col_next, cur_row, cur_col;
    logic [ROW_W-1:0] job_row_reg, job_col_reg;
    quad_flags_t      job_flags_reg, cur_flags;
    logic             job_valid_reg;

    vidx_t vert [BEATS];
    vidx_t idx_reg [BEATS];
    logic  emit_valid_reg, end_reg;
    beat_t beat_reg;

    logic s_accept, m_accept, load_emit, wrap;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_W'(3);
        end else if (cfg_valid) begin
            side_reg <= cfg_data;
        end
    end

    // clamp side length to the supported range
    always_comb begin
        if (side_reg < SIDE_W'(3)) begin
            n_eff = SIDE_W'(3);
        end else if (int'(side_reg) > MAX_SIDE) begin
            n_eff = SIDE_W'(MAX_SIDE);
        end else begin
            n_eff = side_reg;
        end
        last_q = n_eff - SIDE_W'(2);
    end

    assign m_accept  = m_axis_tvalid && m_axis_tready;
    assign load_emit = job_valid_reg &&
                       (!emit_valid_reg || (m_accept && beat_reg == beat_t'(BEATS - 1)));
    assign s_axis_tready = !job_valid_reg || load_emit;
    assign s_accept  = s_axis_tvalid && s_axis_tready;

    // quad selection and counter advance
    always_comb begin
        wrap = s_axis_tdata[0] || int'(row_reg) > int'(last_q) || int'(col_reg) > int'(last_q);
        cur_row = wrap ? '0 : row_reg;
        cur_col = wrap ? '0 : col_reg;
        cur_flags.last_row   = int'(cur_row) == int'(last_q);
        cur_flags.second_row = int'(cur_row) == int'(n_eff) - 3;
        cur_flags.rh         = cur_row[0] ^ cur_col[0];
        cur_flags.mesh_end   = cur_flags.last_row && int'(cur_col) == int'(last_q);
        if (int'(cur_col) >= int'(last_q)) begin
            col_next = '0;
            row_next = (int'(cur_row) >= int'(last_q)) ? '0 : cur_row + ROW_W'(1);
        end else begin
            col_next = cur_col + ROW_W'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                row_reg       <= row_next;
                col_reg       <= col_next;
                job_valid_reg <= 1'b1;
            end else if (load_emit) begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            job_row_reg   <= cur_row;
            job_col_reg   <= cur_col;
            job_flags_reg <= cur_flags;
        end
    end

    ftig_quad_calc #(
        .ROW_W (ROW_W)
    ) u_calc (
        .row    (job_row_reg),
        .col    (job_col_reg),
        .side_n (n_eff),
        .flags  (job_flags_reg),
        .vert   (vert)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_valid_reg <= 1'b0;
            beat_reg       <= '0;
        end else begin
            if (load_emit) begin
                emit_valid_reg <= 1'b1;
                beat_reg       <= '0;
            end else if (m_accept) begin
                if (beat_reg == beat_t'(BEATS - 1)) begin
                    emit_valid_reg <= 1'b0;
                    beat_reg       <= '0;
                end else begin
                    beat_reg <= beat_reg + beat_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_emit) begin
            idx_reg <= vert;
            end_reg <= job_flags_reg.mesh_end;
        end
    end

    assign m_axis_tvalid = emit_valid_reg;
    assign m_axis_tdata  = M_DATA_W'(idx_reg[beat_reg]);
    assign m_axis_tlast  = beat_reg == beat_t'(BEATS - 1);
    assign m_axis_tuser  = end_reg && beat_reg == beat_t'(BEATS - 1);

endmodule

// File: bench/tb_top.sv
// self-checking bench for flat_terrain_index_generator: quad index predictor and scoreboard
// drives side length writes and restart requests, checks every index beat in order
// depends on ftig_pkg and the rtl of flat_terrain_index_generator
module tb_top;
    import ftig_pkg::*;

    localparam int MAX_SIDE      = 256;
    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 300;
    localparam int HOLD_CYCLES   = 120;

    typedef struct packed {
        vidx_t vertex_index;
        logic  last_of_quad;
        logic  last_of_mesh;
    } index_beat_t;

    class quad_index_predictor;
        side_t       side_reg;
        int unsigned quad_row;
        int unsigned quad_col;
        index_beat_t expected_indices[$];
        int          mismatches;

        function new();
            side_reg   = side_t'(3);
            quad_row   = 0;
            quad_col   = 0;
            mismatches = 0;
        endfunction

        function void write_side(side_t value);
            side_reg = value;
        endfunction

        function int pending();
            return expected_indices.size();
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        // note one accepted request beat: compute the six indices of the current quad
        function void take_request(bit restart);
            int unsigned n, last, rowlen, r, c, tl, tr, bl, br;
            int unsigned v[6];
            bit          rh;
            index_beat_t beat;
            int          k;
            n = side_reg;
            if (n < 3) n = 3;
            if (n > MAX_SIDE) n = MAX_SIDE;
            last   = n - 2;
            rowlen = 2 * (n - 1);
            // restart, or counters left outside a shrunken grid
            if (restart || quad_row > last || quad_col > last) begin
                quad_row = 0;
                quad_col = 0;
            end
            r  = quad_row;
            c  = quad_col;
            rh = r[0] ^ c[0];
            if (r == last) begin
                tl = r * rowlen + c;
                bl = tl + n;
            end else if (r == n - 3) begin
                tl = r * rowlen + 2 * c;
                bl = tl + rowlen - c;
            end else begin
                tl = r * rowlen + 2 * c;
                bl = tl + rowlen;
            end
            tr = tl + 1;
            br = bl + 1;
            v[0] = tl;
            v[1] = bl;
            v[2] = rh ? br : tr;
            if (r == last) begin
                v[3] = br;
                v[4] = tr;
                v[5] = rh ? tl : bl;
            end else begin
                v[3] = tr;
                v[4] = rh ? tl : bl;
                v[5] = br;
            end
            for (k = 0; k < BEATS; k++) begin
                beat.vertex_index = vidx_t'(v[k]);
                beat.last_of_quad = (k == BEATS - 1);
                beat.last_of_mesh = (k == BEATS - 1) && (r == last) && (c == last);
                expected_indices.push_back(beat);
            end
            if (c >= last) begin
                quad_col = 0;
                quad_row = (r >= last) ? 0 : r + 1;
            end else begin
                quad_col = c + 1;
            end
        endfunction

        task check_index(logic [M_DATA_W-1:0] data, logic lq, logic lm);
            index_beat_t want;
            if (expected_indices.size() == 0) begin
                report($sformatf("index beat with nothing expected, tdata %0d", data));
                return;
            end
            want = expected_indices.pop_front();
            if (data !== {{(M_DATA_W-IDX_W){1'b0}}, want.vertex_index})
                report($sformatf("vertex_index %0d, want %0d", data, want.vertex_index));
            if (lq !== want.last_of_quad)
                report($sformatf("last_of_quad %b, want %b", lq, want.last_of_quad));
            if (lm !== want.last_of_mesh)
                report($sformatf("last_of_mesh %b, want %b", lm, want.last_of_mesh));
        endtask
    endclass

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [SIDE_W-1:0]   cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;

    quad_index_predictor tracker = new();

    bit no_idle      = 1'b0;
    int hold_request = 0;
    int hold_taken   = 0;
    int hold_left    = 0;
    int sink_wait    = 0;
    bit ready_next   = 1'b0;

    flat_terrain_index_generator #(
        .MAX_SIDE(MAX_SIDE)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // result side: check each beat, then pick how long tready stays low
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tracker.check_index(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            sink_wait = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (hold_request != hold_taken) begin
            hold_taken = hold_request;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= ready_next;
    end

    task automatic write_side(input side_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_side(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input bit restart);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-1){1'b0}}, restart};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tracker.take_request(restart);
        @(negedge aclk);
    endtask

    // sender pauses until every index beat has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int done_items;
        int phase_items;
        int side_pick;
        int phase;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset side length: second-last and last rows, mesh end, wrap, restart
        repeat (6) send_request(1'b0);
        send_request(1'b1);
        drain();
        // top row region, then stop mid last row
        write_side(side_t'(4));
        repeat (7) send_request(1'b0);
        drain();
        // shrink leaves counters outside the grid
        write_side(side_t'(3));
        repeat (2) send_request(1'b0);
        drain();
        // out of range side lengths clamp
        write_side(side_t'(0));
        repeat (2) send_request(1'b0);
        drain();
        write_side(side_t'(511));
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain();
        write_side(side_t'(MAX_SIDE));
        send_request(1'b0);
        drain();
        write_side(side_t'(2));
        send_request(1'b0);
        drain();

        done_items = 0;
        phase      = 0;
        while (done_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       side_pick = $urandom_range(0, 2);
                1:       side_pick = $urandom_range(MAX_SIDE, 511);
                2:       side_pick = $urandom_range(11, MAX_SIDE - 1);
                default: side_pick = $urandom_range(3, 10);
            endcase
            write_side(side_t'(side_pick));
            no_idle     = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(5, 40);
            if (phase == 1) begin
                // long receiver stall so the block backs up its input
                hold_request++;
                phase_items = 30;
            end
            repeat (phase_items) send_request($urandom_range(0, 11) == 0);
            drain();
            done_items += phase_items;
            phase++;
        end

        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 200000);
        $display("Some tests failed");
        $finish;
    end

endmodule
